// File: rtl/rsa_pkg.sv
// rsa_pkg: shared types, codes and defaults for the rotating slot allocator
// no dependencies; imported by rsa_cell, rotating_slot_allocator_steal_oldest, rsa_grant_checker and the testbench

package rsa_pkg;

	// default sizing, handed down through the top-level parameters
	localparam int RSA_POOL_SIZE = 64;
	localparam int RSA_TIME_BITS = 32;

	// fixed field widths of the ports
	localparam int ACTIVE_W = 7;
	localparam int BASE_W   = 16;
	localparam int SLOT_W   = 6;
	localparam int NOW_W    = 32;

	// configuration register indexes
	localparam logic REG_ACTIVE_SLOTS = 1'b0;
	localparam logic REG_POOL_BASE    = 1'b1;

	// request opcodes
	localparam logic OP_ALLOC   = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	// per-slot update broadcast to the cell row
	typedef struct packed {
		logic set;	// mark busy and stamp with the current time
		logic clr;	// mark free
	} cmd_t;

	// width of the scan record handed from cell to cell:
	// valid bit plus two segments of {found, free slot, has busy, old slot, max age}
	function automatic int rec_width(input int pool_size, input int time_bits);
		int idx_w;
		idx_w = $clog2(pool_size);
		return 1 + 2 * (2 + 2 * idx_w + time_bits);
	endfunction

endpackage

// File: rtl/rsa_cell.sv
// rsa_cell: one pool slot (busy mark, start time) and one stage of the scan chain
// depends on rsa_pkg

module rsa_cell
	import rsa_pkg::*;
#(
	parameter int POOL_SIZE = RSA_POOL_SIZE,
	parameter int TIME_BITS = RSA_TIME_BITS,
	parameter int CELL_IDX  = 0,
	localparam int IDX_W    = $clog2(POOL_SIZE),
	localparam int CNT_W    = $clog2(POOL_SIZE + 1),
	localparam int REC_W    = rec_width(POOL_SIZE, TIME_BITS)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cmd_t                 cmd,
	input  logic [IDX_W-1:0]     cmd_slot,
	input  logic [TIME_BITS-1:0] now,
	input  logic [IDX_W-1:0]     scan_start,
	input  logic [CNT_W-1:0]     active_cnt,
	input  logic [REC_W-1:0]     rec_in,
	output logic [REC_W-1:0]     rec_out
);

	typedef struct packed {
		logic                 found;
		logic [IDX_W-1:0]     free_slot;
		logic                 has_busy;
		logic [IDX_W-1:0]     old_slot;
		logic [TIME_BITS-1:0] max_age;
	} seg_t;

	typedef struct packed {
		logic vld;
		seg_t seg_a;	// slots from the start pointer up to the active count
		seg_t seg_b;	// slots below the start pointer, scanned after the wrap
	} rec_t;

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);
	localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(CELL_IDX);

	logic                 busy_q;
	logic [TIME_BITS-1:0] start_time_q;
	logic                 hit;
	logic                 in_act;
	logic                 in_a;
	logic [TIME_BITS-1:0] age;
	rec_t                 rin;
	rec_t                 nxt;
	seg_t                 seg;
	rec_t                 rec_s1;

	assign hit    = (cmd_slot == MY_IDX);
	assign in_act = (MY_CNT < active_cnt);
	assign in_a   = (MY_IDX >= scan_start);
	assign age    = now - start_time_q;
	assign rin    = rec_t'(rec_in);

	// busy mark
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (cmd.set && hit) begin
			busy_q <= 1'b1;
		end else if (cmd.clr && hit) begin
			busy_q <= 1'b0;
		end
	end

	// start time stamp, only read while busy
	always_ff @(posedge clk) begin
		if (cmd.set && hit) begin
			start_time_q <= now;
		end
	end

	// fold this slot into its segment of the record
	always_comb begin
		nxt = rin;
		seg = in_a ? rin.seg_a : rin.seg_b;
		if (!busy_q) begin
			if (!seg.found) begin
				seg.found     = 1'b1;
				seg.free_slot = MY_IDX;
			end
		end else if (!seg.has_busy || age >= seg.max_age) begin
			seg.has_busy = 1'b1;
			seg.old_slot = MY_IDX;
			seg.max_age  = age;
		end
		if (in_act) begin
			if (in_a) begin
				nxt.seg_a = seg;
			end else begin
				nxt.seg_b = seg;
			end
		end
	end

	// hand the record to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_s1 <= '0;
		end else begin
			rec_s1 <= nxt;
		end
	end

	assign rec_out = rec_s1;

endmodule

// File: rtl/rotating_slot_allocator_steal_oldest.sv
// rotating_slot_allocator_steal_oldest: top level, request control, cell row, result register
// depends on rsa_pkg and rsa_cell
//
//  channel | signals                                  | beat taken when
//  --------+------------------------------------------+-----------------------
//  in      | in_valid in_stall op force_req now       | in_valid && !in_stall
//          | release_slot                             |
//  out     | out_valid out_stall granted stolen slot  | out_valid && !out_stall
//          | element_index                            |
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data   | cfg_valid && cfg_ready
//
// a release beat gives its result in the cycle after it is taken
// an allocate beat sends one record down the row of POOL_SIZE cells, one cell
// per cycle (one age subtract and compare per cell), then into the result register
// one request at a time; in_stall is high during a scan and while a result is held
// reset frees every slot and sets the start pointer to slot zero; no clearing pass

module rotating_slot_allocator_steal_oldest
	import rsa_pkg::*;
#(
	parameter int POOL_SIZE = RSA_POOL_SIZE,
	parameter int TIME_BITS = RSA_TIME_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	// request channel
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                op,
	input  logic                force_req,
	input  logic [NOW_W-1:0]    now,
	input  logic [SLOT_W-1:0]   release_slot,
	// result channel
	output logic                out_valid,
	input  logic                out_stall,
	output logic                granted,
	output logic                stolen,
	output logic [SLOT_W-1:0]   slot,
	output logic [BASE_W-1:0]   element_index,
	// configuration channel
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                cfg_index,
	input  logic [BASE_W-1:0]   cfg_data
);

	localparam int IDX_W = $clog2(POOL_SIZE);
	localparam int CNT_W = $clog2(POOL_SIZE + 1);
	localparam int CMP_W = (CNT_W > ACTIVE_W) ? CNT_W : ACTIVE_W;
	localparam int REC_W = rec_width(POOL_SIZE, TIME_BITS);

	localparam logic [CMP_W-1:0] POOL_CMP = CMP_W'(POOL_SIZE);
	localparam logic [CMP_W-1:0] ONE_CMP  = CMP_W'(1);

	// state codes
	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_SCAN = 1'b1;

	typedef struct packed {
		logic                 found;
		logic [IDX_W-1:0]     free_slot;
		logic                 has_busy;
		logic [IDX_W-1:0]     old_slot;
		logic [TIME_BITS-1:0] max_age;
	} seg_t;

	typedef struct packed {
		logic vld;
		seg_t seg_a;
		seg_t seg_b;
	} rec_t;

	logic                 state_q;
	logic [ACTIVE_W-1:0]  active_slots_q;
	logic [BASE_W-1:0]    pool_base_q;
	logic [IDX_W-1:0]     search_start_q;
	logic [IDX_W-1:0]     scan_start_q;
	logic [TIME_BITS-1:0] now_q;
	logic                 force_q;
	logic                 inj_q;

	logic                 out_valid_q;
	logic                 granted_q;
	logic                 stolen_q;
	logic [SLOT_W-1:0]    slot_q;
	logic [BASE_W-1:0]    element_index_q;

	logic [CMP_W-1:0]     act_w;
	logic [CMP_W-1:0]     n_cmp;
	logic [CNT_W-1:0]     active_cnt;
	logic [IDX_W-1:0]     start_eff;
	logic [63:0]          now_wide;
	logic [CMP_W-1:0]     rel_w;
	logic                 rel_ok;
	logic                 in_acc;
	logic                 acc_alloc;
	logic                 acc_rel;

	rec_t                 inj_rec;
	rec_t                 fin;
	logic [REC_W-1:0]     chain [POOL_SIZE+1];

	logic                 done;
	logic                 any_free;
	logic                 b_wins;
	logic                 grant_c;
	logic [IDX_W-1:0]     chosen;
	logic [CMP_W-1:0]     chosen_w;
	logic [CMP_W-1:0]     next_w;
	logic [SLOT_W-1:0]    chosen_slot;

	cmd_t                 cmd;
	logic [IDX_W-1:0]     cmd_slot;

	// active count clamped to 1..POOL_SIZE
	assign act_w      = CMP_W'(active_slots_q);
	assign n_cmp      = (act_w == '0) ? ONE_CMP : ((act_w > POOL_CMP) ? POOL_CMP : act_w);
	assign active_cnt = n_cmp[CNT_W-1:0];
	assign start_eff  = (CMP_W'(search_start_q) < n_cmp) ? search_start_q : '0;
	assign now_wide   = {32'b0, now};
	assign rel_w      = CMP_W'(release_slot);
	assign rel_ok     = (rel_w < n_cmp);

	// handshakes
	assign in_stall  = (state_q == ST_SCAN) || (out_valid_q && out_stall);
	assign in_acc    = in_valid && !in_stall;
	assign acc_alloc = in_acc && (op == OP_ALLOC);
	assign acc_rel   = in_acc && (op == OP_RELEASE);
	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_slots_q <= ACTIVE_W'(64);
			pool_base_q    <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ACTIVE_SLOTS: active_slots_q <= cfg_data[ACTIVE_W-1:0];
				REG_POOL_BASE:    pool_base_q    <= cfg_data;
				default:          pool_base_q    <= pool_base_q;
			endcase
		end
	end

	// request latch for the scan
	always_ff @(posedge clk) begin
		if (acc_alloc) begin
			now_q        <= now_wide[TIME_BITS-1:0];
			force_q      <= force_req;
			scan_start_q <= start_eff;
		end
	end

	// record injection into the first cell
	always_comb begin
		inj_rec     = '0;
		inj_rec.vld = inj_q;
	end

	assign chain[0] = inj_rec;

	// row of slot cells
	for (genvar g = 0; g < POOL_SIZE; g++) begin : g_cell
		rsa_cell #(
			.POOL_SIZE (POOL_SIZE),
			.TIME_BITS (TIME_BITS),
			.CELL_IDX  (g)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.cmd_slot   (cmd_slot),
			.now        (now_q),
			.scan_start (scan_start_q),
			.active_cnt (active_cnt),
			.rec_in     (chain[g]),
			.rec_out    (chain[g+1])
		);
	end

	// decision on the record leaving the last cell
	assign fin      = rec_t'(chain[POOL_SIZE]);
	assign done     = fin.vld && (state_q == ST_SCAN);
	assign any_free = fin.seg_a.found || fin.seg_b.found;
	assign b_wins   = fin.seg_b.has_busy && (fin.seg_b.max_age >= fin.seg_a.max_age);
	assign grant_c  = any_free || force_q;

	always_comb begin
		if (fin.seg_a.found) begin
			chosen = fin.seg_a.free_slot;
		end else if (fin.seg_b.found) begin
			chosen = fin.seg_b.free_slot;
		end else if (b_wins) begin
			chosen = fin.seg_b.old_slot;
		end else begin
			chosen = fin.seg_a.old_slot;
		end
	end

	assign chosen_w    = CMP_W'(chosen);
	assign chosen_slot = chosen_w[SLOT_W-1:0];
	assign next_w      = chosen_w + ONE_CMP;

	// slot update broadcast: stamp on grant, clear on release
	always_comb begin
		cmd.set  = done && grant_c;
		cmd.clr  = acc_rel && rel_ok;
		cmd_slot = done ? chosen : rel_w[IDX_W-1:0];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			inj_q          <= 1'b0;
			search_start_q <= '0;
		end else begin
			inj_q <= acc_alloc;
			case (state_q)
				ST_IDLE: begin
					if (acc_alloc) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (fin.vld) begin
						state_q <= ST_IDLE;
						if (grant_c) begin
							search_start_q <= (next_w >= n_cmp) ? '0 : next_w[IDX_W-1:0];
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (acc_rel || done) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (acc_rel) begin
			granted_q       <= rel_ok;
			stolen_q        <= 1'b0;
			slot_q          <= release_slot;
			element_index_q <= pool_base_q + BASE_W'(release_slot);
		end else if (done) begin
			granted_q       <= grant_c;
			stolen_q        <= grant_c && !any_free;
			slot_q          <= grant_c ? chosen_slot : '0;
			element_index_q <= grant_c ? (pool_base_q + BASE_W'(chosen_slot)) : '0;
		end
	end

	assign out_valid     = out_valid_q;
	assign granted       = granted_q;
	assign stolen        = stolen_q;
	assign slot          = slot_q;
	assign element_index = element_index_q;

	// a finished scan always finds the result register empty
	assert property (@(posedge clk) disable iff (!arst_n) fin.vld |-> !out_valid_q)
		else $error("scan finished while a result was still held");

	// a record leaves the row only during a scan
	assert property (@(posedge clk) disable iff (!arst_n) fin.vld |-> state_q == ST_SCAN)
		else $error("scan record outside of a scan");

	// a release beat shows its result on the next cycle
	assert property (@(posedge clk) disable iff (!arst_n) acc_rel |=> out_valid_q)
		else $error("release result missing");

	// a steal is always a grant
	assert property (@(posedge clk) disable iff (!arst_n) (out_valid_q && stolen_q) |-> granted_q)
		else $error("stolen result without grant");

endmodule

// File: bench/rsa_grant_checker.sv
// rsa_grant_checker: watches the request, result and register channels of the allocator,
// predicts every result beat and compares it field by field
// depends on rsa_pkg

module rsa_grant_checker
	import rsa_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_stall,
	input  logic                op,
	input  logic                force_req,
	input  logic [NOW_W-1:0]    now,
	input  logic [SLOT_W-1:0]   release_slot,
	input  logic                out_valid,
	input  logic                out_stall,
	input  logic                granted,
	input  logic                stolen,
	input  logic [SLOT_W-1:0]   slot,
	input  logic [BASE_W-1:0]   element_index,
	input  logic                cfg_valid,
	input  logic                cfg_ready,
	input  logic                cfg_index,
	input  logic [BASE_W-1:0]   cfg_data,
	output int                  fail_count,
	output int                  pending,
	output int                  steals,
	output int                  refusals
);

	typedef struct packed {
		logic                ok;
		logic                took;
		logic [SLOT_W-1:0]   idx;
		logic [BASE_W-1:0]   elem;
	} grant_t;

	// shadow of the pool and its registers
	bit                  slot_taken [RSA_POOL_SIZE];
	bit [NOW_W-1:0]      stamp [RSA_POOL_SIZE];
	int                  next_scan;
	bit [ACTIVE_W-1:0]   active_reg;
	bit [BASE_W-1:0]     base_reg;
	grant_t              expected_grants[$];

	// apply one request to the shadow pool and return the grant it should produce
	function automatic grant_t serve_request(input logic rq_op, input logic rq_force,
			input logic [NOW_W-1:0] t, input logic [SLOT_W-1:0] rel);
		int n;
		int first;
		int p;
		int i;
		int victim;
		bit found;
		logic [NOW_W-1:0] age;
		logic [NOW_W-1:0] best_age;
		grant_t g;
		n = (active_reg == 0) ? 1 :
			(active_reg > RSA_POOL_SIZE) ? RSA_POOL_SIZE : int'(active_reg);
		g = '0;
		if (rq_op == OP_RELEASE) begin
			g.idx = rel;
			g.elem = base_reg + rel;
			if (rel < n) begin
				slot_taken[rel] = 1'b0;
				g.ok = 1'b1;
			end
			return g;
		end
		// a stale pointer restarts the scan at slot zero
		first = (next_scan < n) ? next_scan : 0;
		found = 1'b0;
		victim = 0;
		best_age = '0;
		p = 0;
		for (i = 0; i < n && !found; i++) begin
			p = (first + i) % n;
			if (!slot_taken[p])
				found = 1'b1;
			else begin
				// equal ages: the slot met later wins
				age = t - stamp[p];
				if (age >= best_age) begin
					victim = p;
					best_age = age;
				end
			end
		end
		if (found)
			victim = p;
		else if (!rq_force) begin
			refusals++;
			return g;
		end else begin
			g.took = 1'b1;
			steals++;
		end
		slot_taken[victim] = 1'b1;
		stamp[victim] = t;
		next_scan = (victim + 1 >= n) ? 0 : victim + 1;
		g.ok = 1'b1;
		g.idx = SLOT_W'(victim);
		g.elem = base_reg + g.idx;
		return g;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		fail_count++;
		if (fail_count <= 40)
			$display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
	endtask

	// register writes, result comparison, request prediction
	always @(posedge clk or negedge arst_n) begin
		grant_t want;
		if (!arst_n) begin
			foreach (slot_taken[k])
				slot_taken[k] = 1'b0;
			next_scan = 0;
			active_reg = 7'd64;
			base_reg = '0;
			expected_grants.delete();
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_ACTIVE_SLOTS)
					active_reg = cfg_data[ACTIVE_W-1:0];
				else
					base_reg = cfg_data;
			end
			if (out_valid && !out_stall) begin
				if (expected_grants.size() == 0)
					report_mismatch("result beat with nothing outstanding",
						{granted, stolen, slot, element_index}, 0);
				else begin
					want = expected_grants.pop_front();
					if (granted !== want.ok)
						report_mismatch("granted", granted, want.ok);
					if (stolen !== want.took)
						report_mismatch("stolen", stolen, want.took);
					if (slot !== want.idx)
						report_mismatch("slot", slot, want.idx);
					if (element_index !== want.elem)
						report_mismatch("element_index", element_index, want.elem);
				end
			end
			if (in_valid && !in_stall)
				expected_grants.push_back(serve_request(op, force_req, now, release_slot));
			pending <= expected_grants.size();
		end
	end

endmodule

// File: bench/rotating_slot_allocator_steal_oldest_tb.sv
// rotating_slot_allocator_steal_oldest_tb: clock, reset, request and register stimulus,
// result stall bursts, watchdog and verdict
// depends on rsa_pkg, rotating_slot_allocator_steal_oldest and rsa_grant_checker

module rotating_slot_allocator_steal_oldest_tb;
	import rsa_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int REQUEST_GOAL = 650;
	localparam int CALM_AFTER = 560;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic                op = OP_ALLOC;
	logic                force_req = 1'b0;
	logic [NOW_W-1:0]    now = '0;
	logic [SLOT_W-1:0]   release_slot = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic                granted;
	logic                stolen;
	logic [SLOT_W-1:0]   slot;
	logic [BASE_W-1:0]   element_index;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic                cfg_index = REG_ACTIVE_SLOTS;
	logic [BASE_W-1:0]   cfg_data = '0;

	int fail_count;
	int pending;
	int steals;
	int refusals;

	int requests_sent = 0;
	int settings_used = 0;
	int live = RSA_POOL_SIZE;
	bit idle_on = 1'b1;
	int stall_burst = 0;

	always #2 clk = ~clk;

	rotating_slot_allocator_steal_oldest u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .op(op), .force_req(force_req),
		.now(now), .release_slot(release_slot),
		.out_valid(out_valid), .out_stall(out_stall), .granted(granted), .stolen(stolen),
		.slot(slot), .element_index(element_index),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	rsa_grant_checker u_check (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .op(op), .force_req(force_req),
		.now(now), .release_slot(release_slot),
		.out_valid(out_valid), .out_stall(out_stall), .granted(granted), .stolen(stolen),
		.slot(slot), .element_index(element_index),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.fail_count(fail_count), .pending(pending), .steals(steals), .refusals(refusals)
	);

	// result side: stall bursts between free-running stretches
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_burst <= 0;
		end else if (stall_burst != 0)
			stall_burst <= stall_burst - 1;
		else if (idle_on && $urandom_range(0, 2) == 0) begin
			out_stall <= 1'b1;
			stall_burst <= $urandom_range(0, 17);
		end else begin
			out_stall <= 1'b0;
			stall_burst <= $urandom_range(0, 39);
		end
	end

	// watchdog: ends the run after too many cycles without any beat
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("rotating_slot_allocator_steal_oldest: mismatch");
		$finish;
	end

	// drain all outstanding results, then write both registers
	task automatic set_pool(input logic [ACTIVE_W-1:0] slots, input logic [BASE_W-1:0] base);
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		cfg_valid <= 1'b1;
		cfg_index <= REG_ACTIVE_SLOTS;
		cfg_data <= BASE_W'(slots);
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= REG_POOL_BASE;
		cfg_data <= base;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		live = (slots == 0) ? 1 : (slots > RSA_POOL_SIZE) ? RSA_POOL_SIZE : int'(slots);
		settings_used++;
	endtask

	// one request beat, with an optional sender gap in front
	task automatic send_request(input logic rq_op, input logic rq_force,
			input logic [NOW_W-1:0] t, input logic [SLOT_W-1:0] rel);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= rq_op;
		force_req <= rq_force;
		now <= t;
		release_slot <= rel;
		do @(posedge clk); while (in_stall);
		requests_sent++;
	endtask

	initial begin
		logic [NOW_W-1:0] tick;
		logic [ACTIVE_W-1:0] pick_slots;
		logic [BASE_W-1:0] pick_base;
		logic rq_op;
		logic [SLOT_W-1:0] rel;
		int len;
		int pick;
		bit first_random;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// four slots, base near the top so element indexes wrap
		set_pool(7'd4, 16'hFFFE);
		send_request(OP_RELEASE, 1'b0, 32'd0, 6'd0);
		send_request(OP_ALLOC, 1'b0, 32'd100, 6'd0);
		send_request(OP_ALLOC, 1'b0, 32'd100, 6'd0);
		send_request(OP_ALLOC, 1'b0, 32'd50, 6'd0);
		send_request(OP_ALLOC, 1'b1, 32'hFFFF_FFF0, 6'd0);
		send_request(OP_ALLOC, 1'b0, 32'd200, 6'd0);
		send_request(OP_ALLOC, 1'b1, 32'd200, 6'd0);
		send_request(OP_RELEASE, 1'b0, 32'd0, 6'd5);
		send_request(OP_RELEASE, 1'b1, 32'hFFFF_FFFF, 6'd63);
		send_request(OP_RELEASE, 1'b0, 32'd0, 6'd1);
		send_request(OP_ALLOC, 1'b0, 32'hFFFF_FFFF, 6'd0);
		send_request(OP_ALLOC, 1'b1, 32'd0, 6'd0);

		// zero active count behaves as one slot
		set_pool(7'd0, 16'h0000);
		send_request(OP_RELEASE, 1'b0, 32'd0, 6'd0);
		send_request(OP_ALLOC, 1'b0, 32'd7, 6'd0);
		send_request(OP_ALLOC, 1'b0, 32'd7, 6'd0);
		send_request(OP_ALLOC, 1'b1, 32'd7, 6'd0);
		send_request(OP_RELEASE, 1'b0, 32'd0, 6'd1);

		// two slots stamped alike, then a forced steal on a tie
		set_pool(7'd2, 16'h8000);
		send_request(OP_RELEASE, 1'b0, 32'd0, 6'd0);
		send_request(OP_RELEASE, 1'b0, 32'd0, 6'd1);
		send_request(OP_ALLOC, 1'b0, 32'd500, 6'd0);
		send_request(OP_ALLOC, 1'b0, 32'd500, 6'd0);
		send_request(OP_ALLOC, 1'b1, 32'd505, 6'd0);

		// oversized active count saturates to the pool; leaves the pointer past slot 3
		set_pool(7'd127, 16'h5A5A);
		send_request(OP_ALLOC, 1'b1, 32'h1234_5678, 6'd0);
		send_request(OP_ALLOC, 1'b0, 32'h1234_5679, 6'd0);
		send_request(OP_ALLOC, 1'b0, 32'h1234_5679, 6'd0);

		// random phases, each with its own pool setting
		tick = $urandom;
		first_random = 1'b1;
		while (requests_sent < REQUEST_GOAL) begin
			case ($urandom_range(0, 9))
				0: pick_slots = 7'd0;
				1: pick_slots = 7'd1;
				2: pick_slots = 7'd64;
				3: pick_slots = ACTIVE_W'($urandom_range(65, 127));
				default: pick_slots = ACTIVE_W'($urandom_range(2, 8));
			endcase
			// first phase after the big pool exercises the stale start pointer
			if (first_random)
				pick_slots = 7'd3;
			first_random = 1'b0;
			case ($urandom_range(0, 3))
				0: pick_base = 16'h0000;
				1: pick_base = 16'hFFFF;
				default: pick_base = BASE_W'($urandom);
			endcase
			set_pool(pick_slots, pick_base);
			len = (live > 16) ? $urandom_range(90, 150) : $urandom_range(20, 45);
			// the last phase stops at the request goal
			if (len > REQUEST_GOAL - requests_sent)
				len = REQUEST_GOAL - requests_sent;
			repeat (len) begin
				if (requests_sent >= CALM_AFTER)
					idle_on <= 1'b0;
				// time mostly creeps forward, with ties, jumps and wraps
				pick = $urandom_range(0, 19);
				if (pick == 0)
					tick = $urandom;
				else if (pick == 1)
					tick = 32'hFFFF_FFF8 + $urandom_range(0, 7);
				else
					tick = tick + $urandom_range(0, 4);
				rq_op = ($urandom_range(0, 99) < ((live > 16) ? 85 : 60)) ? OP_ALLOC : OP_RELEASE;
				if (rq_op == OP_ALLOC || $urandom_range(0, 4) == 0)
					rel = SLOT_W'($urandom_range(0, 63));
				else
					rel = SLOT_W'($urandom_range(0, live - 1));
				send_request(rq_op, 1'($urandom_range(0, 1)), tick, rel);
			end
		end

		// drain and let the block settle
		in_valid <= 1'b0;
		idle_on <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (RSA_POOL_SIZE + 8) @(posedge clk);

		$display("covered %0d requests under %0d pool settings", requests_sent, settings_used);
		$display("including %0d oldest-slot steals and %0d refused allocations",
			steals, refusals);
		if (fail_count == 0)
			$display("rotating_slot_allocator_steal_oldest: match");
		else
			$display("rotating_slot_allocator_steal_oldest: mismatch");
		$finish;
	end

endmodule
